// ===== sv/gda_pkg.sv =====
// shared types, constants and calendar tables for the date arithmetic block
package gda_pkg;

  // default sizes
  localparam int YEAR_BITS_DEF = 12;
  localparam int ADD_BITS_DEF  = 16;

  // fixed field widths
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int DIFF_W  = 22;
  localparam int YRS_W   = 13;
  localparam int DOY_W   = 9;

  // divide by 100 as multiply by reciprocal, exact for years below 2^14
  localparam int DIV100_MUL   = 5243;
  localparam int DIV100_MUL_W = 13;
  localparam int DIV100_SHIFT = 19;

  // calendar constants
  localparam int YEAR_DAYS            = 365;
  localparam int FOUR_YEAR_DAYS       = 1460;
  localparam int CENTURY_DAYS         = 36524;
  localparam int YEARS_PER_CENTURY    = 100;
  localparam int YEARS_PER_LEAP_CYCLE = 4;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_LAST  = 5'd31;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_A,
    ST_DIV_B,
    ST_EVAL,
    ST_DIFF,
    ST_WALK,
    ST_MONTH,
    ST_DONE
  } gda_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic div_a;
    logic div_b;
    logic eval;
    logic diff;
    logic walk;
    logic month;
    logic out_load;
  } gda_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic invalid;
    logic walk_end;
    logic walk_ovf;
    logic month_end;
    logic out_free;
  } gda_stat_t;

  // days in month, zero for a month code that means nothing
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] n;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     n = 5'd30;
      4'd2:                                        n = leap ? 5'd29 : 5'd28;
      default:                                     n = 5'd0;
    endcase
    return n;
  endfunction

  // days in the months before m of a common year
  function automatic logic [DOY_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] n;
    unique case (m)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== sv/gda_ctrl.sv =====
// sequencer for the date arithmetic block
module gda_ctrl
  import gda_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  gda_stat_t stat,
  output gda_cmd_t  cmd
);

  gda_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DIV_A;
      end
      ST_DIV_A: state_nxt = ST_DIV_B;
      ST_DIV_B: state_nxt = ST_EVAL;
      ST_EVAL:  state_nxt = ST_DIFF;
      ST_DIFF: begin
        state_nxt = stat.invalid ? ST_DONE : ST_WALK;
      end
      ST_WALK: begin
        priority if (stat.walk_ovf) state_nxt = ST_DONE;
        else if (stat.walk_end)     state_nxt = ST_MONTH;
        else                        state_nxt = ST_WALK;
      end
      ST_MONTH: begin
        if (stat.month_end) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd          = '0;
    in_ready     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_DIV_A: cmd.div_a = 1'b1;
      ST_DIV_B: cmd.div_b = 1'b1;
      ST_EVAL:  cmd.eval  = 1'b1;
      ST_DIFF:  cmd.diff  = 1'b1;
      ST_WALK:  cmd.walk  = 1'b1;
      ST_MONTH: cmd.month = 1'b1;
      ST_DONE:  cmd.out_load = stat.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule

// ===== sv/gda_dp.sv =====
// datapath: divide-by-100 unit, date evaluation, difference, year and month walk
module gda_dp
  import gda_pkg::*;
#(
  parameter int YEAR_BITS = YEAR_BITS_DEF,
  parameter int ADD_BITS  = ADD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  gda_cmd_t                    cmd,
  output gda_stat_t                   stat,
  input  logic [YEAR_BITS-1:0]        in_year_a,
  input  logic [MONTH_W-1:0]          in_month_a,
  input  logic [DAY_W-1:0]            in_day_a,
  input  logic [YEAR_BITS-1:0]        in_year_b,
  input  logic [MONTH_W-1:0]          in_month_b,
  input  logic [DAY_W-1:0]            in_day_b,
  input  logic [ADD_BITS-1:0]         in_add_days,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [DIFF_W-1:0]    out_day_difference,
  output logic signed [YRS_W-1:0]     out_whole_years,
  output logic                        out_a_after_b,
  output logic                        out_a_before_b,
  output logic                        out_dates_equal,
  output logic [YEAR_BITS-1:0]        out_sum_year,
  output logic [MONTH_W-1:0]          out_sum_month,
  output logic [DAY_W-1:0]            out_sum_day,
  output logic                        out_year_overflow,
  output logic                        out_date_invalid
);

  localparam int QW    = YEAR_BITS - 6;
  localparam int PW    = YEAR_BITS + DIV100_MUL_W;
  localparam int YW1   = YEAR_BITS + 1;
  localparam int REM_W = ADD_BITS + 2;
  localparam int CMP_W = (REM_W > 17) ? REM_W : 17;
  localparam int DCW   = YEAR_BITS + 10;
  localparam logic [YEAR_BITS-1:0] YEAR_MAX = '1;

  // year mod 100 from year and year / 100
  function automatic logic [6:0] rem100(input logic [YEAR_BITS-1:0] y,
                                        input logic [QW-1:0] q);
    logic [YEAR_BITS-1:0] h;
    h = YEAR_BITS'(q * YEARS_PER_CENTURY);
    return 7'(y - h);
  endfunction

  // gregorian leap rule on the century split
  function automatic logic leap_of(input logic [QW-1:0] q, input logic [6:0] r);
    return (r == 7'd0) ? (q[1:0] == 2'd0) : (r[1:0] == 2'd0);
  endfunction

  // leap years in 0 .. y-1: ceil(y/4) - ceil(y/100) + ceil(y/400)
  function automatic logic [YEAR_BITS-1:0] leaps_before(input logic [YEAR_BITS-1:0] y,
                                                        input logic [QW-1:0] q,
                                                        input logic [6:0] r);
    logic [YW1-1:0] cq;
    logic [YW1-1:0] y4;
    logic [YW1-1:0] c4;
    cq = YW1'(q) + YW1'(r != 7'd0);
    y4 = (YW1'(y) + YW1'(3)) >> 2;
    c4 = (cq + YW1'(3)) >> 2;
    return YEAR_BITS'(y4 - cq + c4);
  endfunction

  // captured word
  logic [YEAR_BITS-1:0] ya_r, yb_r;
  logic [MONTH_W-1:0]   ma_r, mb_r;
  logic [DAY_W-1:0]     da_r, db_r;
  logic [ADD_BITS-1:0]  add_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ya_r  <= in_year_a;
      ma_r  <= in_month_a;
      da_r  <= in_day_a;
      yb_r  <= in_year_b;
      mb_r  <= in_month_b;
      db_r  <= in_day_b;
      add_r <= in_add_days;
    end
  end

  // shared divide-by-100 multiplier
  logic [YEAR_BITS-1:0] div_op;
  logic [PW-1:0]        div_prod;
  logic [QW-1:0]        qa_r, qb_r;

  assign div_op   = cmd.div_b ? yb_r : ya_r;
  assign div_prod = PW'(div_op) * PW'(DIV100_MUL);

  always_ff @(posedge clk) begin
    if (cmd.div_a) qa_r <= QW'(div_prod >> DIV100_SHIFT);
    if (cmd.div_b) qb_r <= QW'(div_prod >> DIV100_SHIFT);
  end

  // per-date evaluation: validity, day of year, leap count
  logic [6:0]         ra, rb;
  logic               leap_a, leap_b;
  logic [DAY_W-1:0]   mlen_a, mlen_b;
  logic               valid_a, valid_b;
  logic [DOY_W-1:0]   doy_a, doy_b;

  assign ra      = rem100(ya_r, qa_r);
  assign rb      = rem100(yb_r, qb_r);
  assign leap_a  = leap_of(qa_r, ra);
  assign leap_b  = leap_of(qb_r, rb);
  assign mlen_a  = month_days(ma_r, leap_a);
  assign mlen_b  = month_days(mb_r, leap_b);
  assign valid_a = (ma_r >= MONTH_JAN) && (ma_r <= MONTH_DEC) && (da_r != '0) &&
                   (da_r <= mlen_a);
  assign valid_b = (mb_r >= MONTH_JAN) && (mb_r <= MONTH_DEC) && (db_r != '0) &&
                   (db_r <= mlen_b);
  assign doy_a   = days_before_month(ma_r) + DOY_W'(da_r) +
                   DOY_W'(leap_a && (ma_r > MONTH_FEB));
  assign doy_b   = days_before_month(mb_r) + DOY_W'(db_r) +
                   DOY_W'(leap_b && (mb_r > MONTH_FEB));

  logic [6:0]           ra_r;
  logic [DOY_W-1:0]     doy_a_r, doy_b_r;
  logic [YEAR_BITS-1:0] lp_a_r, lp_b_r;
  logic                 invalid_r;

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      ra_r      <= ra;
      doy_a_r   <= doy_a;
      doy_b_r   <= doy_b;
      lp_a_r    <= leaps_before(ya_r, qa_r, ra);
      lp_b_r    <= leaps_before(yb_r, qb_r, rb);
      invalid_r <= !(valid_a && valid_b);
    end
  end

  // day difference, modular in DCW bits, exact within range
  logic [DCW-1:0]        diff_nxt;
  logic signed [DCW-1:0] diff_r;

  assign diff_nxt = (DCW'(ya_r) - DCW'(yb_r)) * DCW'(YEAR_DAYS) +
                    DCW'(lp_a_r) - DCW'(lp_b_r) + DCW'(doy_a_r) - DCW'(doy_b_r);

  always_ff @(posedge clk) begin
    if (cmd.diff) diff_r <= diff_nxt;
  end

  // year walk: century, four-year and single-year steps
  logic [REM_W-1:0]     rem_r;
  logic [YEAR_BITS-1:0] wy_r;
  logic [QW-1:0]        wc_r;
  logic [6:0]           wr_r;
  logic [MONTH_W-1:0]   m_r;
  logic                 ovf_r;

  logic                 leap_w;
  logic [CMP_W-1:0]     rem_c, len1, len4, len100;
  logic [YEAR_BITS-1:0] room;
  logic                 fit1, fit4, fit100;
  logic                 walk_step;
  logic [REM_W-1:0]     rem_walk_nxt;
  logic [YEAR_BITS-1:0] wy_nxt;
  logic [QW-1:0]        wc_nxt;
  logic [6:0]           wr_nxt;

  assign leap_w = leap_of(wc_r, wr_r);
  assign rem_c  = CMP_W'(rem_r);
  assign len1   = CMP_W'(YEAR_DAYS) + CMP_W'(leap_w);
  assign len4   = CMP_W'(FOUR_YEAR_DAYS) + CMP_W'(leap_w);
  assign len100 = CMP_W'(CENTURY_DAYS) + CMP_W'(leap_w);
  assign room   = YEAR_MAX - wy_r;
  assign fit100 = (wr_r == 7'd0) && (room >= YEAR_BITS'(YEARS_PER_CENTURY)) &&
                  (rem_c >= len100);
  assign fit4   = (wr_r[1:0] == 2'd0) && (room >= YEAR_BITS'(YEARS_PER_LEAP_CYCLE)) &&
                  (rem_c >= len4);
  assign fit1   = rem_c >= len1;

  always_comb begin
    rem_walk_nxt = rem_r;
    wy_nxt       = wy_r;
    wc_nxt       = wc_r;
    wr_nxt       = wr_r;
    walk_step    = 1'b0;
    priority if (fit100) begin
      walk_step    = 1'b1;
      rem_walk_nxt = REM_W'(rem_c - len100);
      wy_nxt       = wy_r + YEAR_BITS'(YEARS_PER_CENTURY);
      wc_nxt       = wc_r + QW'(1);
    end else if (fit4) begin
      walk_step    = 1'b1;
      rem_walk_nxt = REM_W'(rem_c - len4);
      wy_nxt       = wy_r + YEAR_BITS'(YEARS_PER_LEAP_CYCLE);
      if (wr_r == 7'(YEARS_PER_CENTURY - YEARS_PER_LEAP_CYCLE)) begin
        wr_nxt = 7'd0;
        wc_nxt = wc_r + QW'(1);
      end else begin
        wr_nxt = wr_r + 7'(YEARS_PER_LEAP_CYCLE);
      end
    end else if (fit1 && (room != '0)) begin
      walk_step    = 1'b1;
      rem_walk_nxt = REM_W'(rem_c - len1);
      wy_nxt       = wy_r + YEAR_BITS'(1);
      if (wr_r == 7'(YEARS_PER_CENTURY - 1)) begin
        wr_nxt = 7'd0;
        wc_nxt = wc_r + QW'(1);
      end else begin
        wr_nxt = wr_r + 7'd1;
      end
    end else begin
      walk_step = 1'b0;
    end
  end

  // month walk inside the final year
  logic [DAY_W-1:0] mlen_w;
  logic             month_fit;

  assign mlen_w    = month_days(m_r, leap_w);
  assign month_fit = (m_r < MONTH_DEC) && (rem_c >= CMP_W'(mlen_w));

  // walk registers
  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      rem_r <= REM_W'(REM_W'(doy_a_r) + REM_W'(add_r) - REM_W'(1));
      wy_r  <= ya_r;
      wc_r  <= qa_r;
      wr_r  <= ra_r;
      m_r   <= MONTH_JAN;
      ovf_r <= 1'b0;
    end else if (cmd.walk) begin
      if (walk_step) begin
        rem_r <= rem_walk_nxt;
        wy_r  <= wy_nxt;
        wc_r  <= wc_nxt;
        wr_r  <= wr_nxt;
      end else if (fit1) begin
        ovf_r <= 1'b1;
      end
    end else if (cmd.month && month_fit) begin
      rem_r <= REM_W'(rem_c - CMP_W'(mlen_w));
      m_r   <= m_r + MONTH_W'(1);
    end
  end

  // status to the sequencer
  logic out_valid_r;

  assign stat.invalid   = invalid_r;
  assign stat.walk_ovf  = fit1 && !walk_step;
  assign stat.walk_end  = !fit1;
  assign stat.month_end = !month_fit;
  assign stat.out_free  = !out_valid_r || out_ready;

  // comparison and whole years
  logic                 a_md_later;
  logic [YRS_W-1:0]     yrs_nxt;
  logic [YEAR_BITS+8:0] key_a, key_b;

  assign a_md_later = (ma_r > mb_r) || ((ma_r == mb_r) && (da_r > db_r));
  assign yrs_nxt    = YRS_W'(yb_r) - YRS_W'(ya_r) - YRS_W'(a_md_later);
  assign key_a      = {ya_r, ma_r, da_r};
  assign key_b      = {yb_r, mb_r, db_r};

  // result register
  logic signed [DIFF_W-1:0] diff_out_r;
  logic signed [YRS_W-1:0]  yrs_r;
  logic                     after_r, before_r, equal_r;
  logic [YEAR_BITS-1:0]     sum_year_r;
  logic [MONTH_W-1:0]       sum_month_r;
  logic [DAY_W-1:0]         sum_day_r;
  logic                     ovf_out_r, invalid_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (invalid_r) begin
        diff_out_r    <= '0;
        yrs_r         <= '0;
        after_r       <= 1'b0;
        before_r      <= 1'b0;
        equal_r       <= 1'b0;
        sum_year_r    <= '0;
        sum_month_r   <= '0;
        sum_day_r     <= '0;
        ovf_out_r     <= 1'b0;
        invalid_out_r <= 1'b1;
      end else begin
        diff_out_r    <= DIFF_W'(diff_r);
        yrs_r         <= yrs_nxt;
        after_r       <= key_a > key_b;
        before_r      <= key_a < key_b;
        equal_r       <= key_a == key_b;
        invalid_out_r <= 1'b0;
        ovf_out_r     <= ovf_r;
        if (ovf_r) begin
          sum_year_r  <= YEAR_MAX;
          sum_month_r <= MONTH_DEC;
          sum_day_r   <= DAY_LAST;
        end else begin
          sum_year_r  <= wy_r;
          sum_month_r <= m_r;
          sum_day_r   <= DAY_W'(rem_r + REM_W'(1));
        end
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_day_difference = diff_out_r;
  assign out_whole_years    = yrs_r;
  assign out_a_after_b      = after_r;
  assign out_a_before_b     = before_r;
  assign out_dates_equal    = equal_r;
  assign out_sum_year       = sum_year_r;
  assign out_sum_month      = sum_month_r;
  assign out_sum_day        = sum_day_r;
  assign out_year_overflow  = ovf_out_r;
  assign out_date_invalid   = invalid_out_r;

endmodule

// ===== sv/gregorian_date_arithmetic.sv =====
// Gregorian date arithmetic: takes dates A and B and a day count per input word and
// returns one result word with the signed day difference A minus B, the whole years
// completed from A to B, the order of A against B, and A advanced by the day count
// (saturating at December 31 of the highest year, with year_overflow set). A month or
// day out of range in either date sets date_invalid and zeroes everything else. One
// word is worked on at a time; a finished result sits in an output register, so the
// next word is taken while the previous result waits. A word is captured, both years
// are divided by 100 in turn, the dates are evaluated and the difference is formed;
// an invalid word then goes straight to the result register, while a valid word walks
// the years and then the months of the advanced date, skipping the month walk when
// the advance runs past the highest year. The year walk takes a century, a four-year
// block or a single year per cycle, and the month walk steps a month at a time.
module gregorian_date_arithmetic
  import gda_pkg::*;
#(
  parameter int YEAR_BITS = YEAR_BITS_DEF,
  parameter int ADD_BITS  = ADD_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [YEAR_BITS-1:0]     in_year_a,
  input  logic [MONTH_W-1:0]       in_month_a,
  input  logic [DAY_W-1:0]         in_day_a,
  input  logic [YEAR_BITS-1:0]     in_year_b,
  input  logic [MONTH_W-1:0]       in_month_b,
  input  logic [DAY_W-1:0]         in_day_b,
  input  logic [ADD_BITS-1:0]      in_add_days,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DIFF_W-1:0] out_day_difference,
  output logic signed [YRS_W-1:0]  out_whole_years,
  output logic                     out_a_after_b,
  output logic                     out_a_before_b,
  output logic                     out_dates_equal,
  output logic [YEAR_BITS-1:0]     out_sum_year,
  output logic [MONTH_W-1:0]       out_sum_month,
  output logic [DAY_W-1:0]         out_sum_day,
  output logic                     out_year_overflow,
  output logic                     out_date_invalid
);

  gda_cmd_t  cmd;
  gda_stat_t stat;

  // sequencer
  gda_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  gda_dp #(
    .YEAR_BITS (YEAR_BITS),
    .ADD_BITS  (ADD_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_year_a          (in_year_a),
    .in_month_a         (in_month_a),
    .in_day_a           (in_day_a),
    .in_year_b          (in_year_b),
    .in_month_b         (in_month_b),
    .in_day_b           (in_day_b),
    .in_add_days        (in_add_days),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_day_difference (out_day_difference),
    .out_whole_years    (out_whole_years),
    .out_a_after_b      (out_a_after_b),
    .out_a_before_b     (out_a_before_b),
    .out_dates_equal    (out_dates_equal),
    .out_sum_year       (out_sum_year),
    .out_sum_month      (out_sum_month),
    .out_sum_day        (out_sum_day),
    .out_year_overflow  (out_year_overflow),
    .out_date_invalid   (out_date_invalid)
  );

  // exactly one ordering flag on a valid result
  a_order_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_date_invalid) |->
      $onehot({out_a_after_b, out_a_before_b, out_dates_equal}))
    else $error("ordering flags not one-hot");

  // invalid result carries nothing else
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_date_invalid) |->
      (out_day_difference == '0) && (out_whole_years == '0) && !out_a_after_b &&
      !out_a_before_b && !out_dates_equal && (out_sum_year == '0) &&
      (out_sum_month == '0) && (out_sum_day == '0) && !out_year_overflow)
    else $error("invalid result has nonzero fields");

  // advanced date has a month in range and a nonzero day
  a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_date_invalid) |->
      (out_sum_month != '0) && (out_sum_month <= MONTH_DEC) && (out_sum_day != '0))
    else $error("advanced date out of range");

  // a loaded result shows up as valid
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid)
    else $error("result load lost");

endmodule
